@@ rtl/salc_pkg.sv @@
// Package for the set-associative LRU cache model: constants, types and helpers.
// Used by the top, front end and back end under rtl; depends on nothing else.
`timescale 1ns / 1ps
package salc_pkg;
    localparam int MaxSetBitsDef = 6;
    localparam int MaxWaysDef = 8;
    localparam int MaxBlockBits = 16;
    localparam int AddrW = 64;
    localparam int TotalW = 32;
    localparam logic [TotalW-1:0] TotalMax = '1;

    localparam logic [1:0] CmdFetch = 2'd0;
    localparam logic [1:0] CmdLoad = 2'd1;
    localparam logic [1:0] CmdStore = 2'd2;
    localparam logic [1:0] CmdModify = 2'd3;

    localparam logic [1:0] OutHit = 2'd0;
    localparam logic [1:0] OutFill = 2'd1;
    localparam logic [1:0] OutEvict = 2'd2;

    localparam logic [1:0] CfgSetBits = 2'd0;
    localparam logic [1:0] CfgBlockBits = 2'd1;
    localparam logic [1:0] CfgWays = 2'd2;

    function automatic logic [TotalW-1:0] sat_inc(input logic [TotalW-1:0] v);
        sat_inc = (v == TotalMax) ? v : v + TotalW'(1);
    endfunction
endpackage

@@ rtl/set_assoc_lru_cache_model_top.sv @@
// Top level of the set-associative LRU cache model: configuration registers,
// front end, back end. Depends on salc_pkg, salc_front, salc_back.
//
//  channel   direction  handshake                  payload
//  access    in         start & !busy              i_command, i_address
//  result    out        o_valid (one cycle)        o_outcome .. o_eviction_total
//  config    in         i_cfg_valid & o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each lookup reads its set in the back end, then compares and writes it back through
// the write port of the set RAM. A load or store does one lookup, a modify does two,
// and a fetch is taken with no lookup; busy stays high until the last lookup has written
// its set back. After reset a clearing pass over all 2**MaxSetBits sets (64 by default)
// runs before the first access is taken. Registers are written only while the block is
// idle. Results cannot be stalled.
`timescale 1ns / 1ps
module set_assoc_lru_cache_model_top
    import salc_pkg::*;
#(
    parameter int MaxSetBits = MaxSetBitsDef,
    parameter int MaxWays = MaxWaysDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_command,
    input  logic [AddrW-1:0]  i_address,
    output logic              o_valid,
    output logic [1:0]        o_outcome,
    output logic              o_last_of_access,
    output logic [TotalW-1:0] o_hit_total,
    output logic [TotalW-1:0] o_miss_total,
    output logic [TotalW-1:0] o_eviction_total,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [4:0]        i_cfg_data
);
    logic [2:0] r_set_bits;
    logic [4:0] r_block_bits;
    logic [3:0] r_ways;
    logic f_busy, req_valid, req_last, req_pop, back_ready;
    logic [MaxSetBits-1:0] req_set;
    logic [AddrW-2:0] req_tag;

    assign busy = f_busy || !back_ready;
    assign o_cfg_ready = !busy && !start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= 3'd1;
            r_block_bits <= 5'd1;
            r_ways <= 4'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CfgSetBits: r_set_bits <= i_cfg_data[2:0];
                CfgBlockBits: r_block_bits <= i_cfg_data;
                CfgWays: r_ways <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    salc_front #(.MaxSetBits(MaxSetBits)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(start && back_ready), .i_command(i_command), .i_address(i_address),
        .i_set_bits(r_set_bits), .i_block_bits(r_block_bits),
        .o_busy(f_busy), .o_req_valid(req_valid), .o_req_set(req_set),
        .o_req_tag(req_tag), .o_req_last(req_last), .i_req_pop(req_pop)
    );

    salc_back #(.MaxSetBits(MaxSetBits), .MaxWays(MaxWays)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ways_in_use(r_ways),
        .i_req_valid(req_valid), .i_req_set(req_set), .i_req_tag(req_tag),
        .i_req_last(req_last), .o_req_pop(req_pop), .o_ready(back_ready),
        .o_done(o_valid), .o_outcome(o_outcome), .o_last_of_access(o_last_of_access),
        .o_hit_total(o_hit_total), .o_miss_total(o_miss_total),
        .o_eviction_total(o_eviction_total)
    );
endmodule

@@ rtl/salc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module salc_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/salc_front.sv @@
// Front end: accepts accesses, drops fetches, splits the address into set and tag,
// and queues one lookup request per lookup. Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_front
    import salc_pkg::*;
#(
    parameter int MaxSetBits = MaxSetBitsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [1:0]            i_command,
    input  logic [AddrW-1:0]      i_address,
    input  logic [2:0]            i_set_bits,
    input  logic [4:0]            i_block_bits,
    output logic                  o_busy,
    output logic                  o_req_valid,
    output logic [MaxSetBits-1:0] o_req_set,
    output logic [AddrW-2:0]      o_req_tag,
    output logic                  o_req_last,
    input  logic                  i_req_pop
);
    localparam int Depth = 2;
    logic [1:0] r_count, n_count;
    logic r_rd, r_wr;
    logic [MaxSetBits-1:0] r_q_set [Depth];
    logic [AddrW-2:0] r_q_tag [Depth];
    logic r_q_last [Depth];
    logic [4:0] sb, bb;
    logic [AddrW-1:0] shifted;
    logic [MaxSetBits-1:0] set_idx;
    logic [AddrW-2:0] tag;
    logic accept, modify;

    always_comb begin
        sb = (i_set_bits == 3'd0) ? 5'd1 : {2'b0, i_set_bits};
        if (sb > 5'(MaxSetBits)) sb = 5'(MaxSetBits);
        bb = (i_block_bits == 5'd0) ? 5'd1 : i_block_bits;
        if (bb > 5'(MaxBlockBits)) bb = 5'(MaxBlockBits);
        shifted = i_address >> bb;
        set_idx = shifted[MaxSetBits-1:0] & MaxSetBits'((1 << sb) - 1);
        tag = (AddrW-1)'(shifted >> sb);
    end

    assign o_busy = (r_count != 2'd0);
    assign accept = i_start && !o_busy && (i_command != CmdFetch);
    assign modify = (i_command == CmdModify);

    always_comb begin
        n_count = r_count;
        if (accept) n_count = modify ? 2'd2 : 2'd1;
        else if (i_req_pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_rd <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) r_rd <= 1'b0;
            else if (i_req_pop) r_rd <= ~r_rd;
        end
        if (accept) begin
            r_q_set[0] <= set_idx;
            r_q_tag[0] <= tag;
            r_q_last[0] <= !modify;
            r_q_set[1] <= set_idx;
            r_q_tag[1] <= tag;
            r_q_last[1] <= 1'b1;
        end
    end

    assign r_wr = 1'b0;
    assign o_req_valid = (r_count != 2'd0) && !r_wr;
    assign o_req_set = r_q_set[r_rd];
    assign o_req_tag = r_q_tag[r_rd];
    assign o_req_last = r_q_last[r_rd];

    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_req_pop |-> o_req_valid)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= 2'd2)
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_count == 2'd1 || r_count == 2'd2))
        else $error("accepted access not queued");
endmodule

@@ rtl/salc_back.sv @@
// Back end: per lookup reads one set, compares ways, picks the victim, updates ages,
// writes the set back and reports outcome and totals. Depends on salc_pkg, salc_ram.
`timescale 1ns / 1ps
module salc_back
    import salc_pkg::*;
#(
    parameter int MaxSetBits = MaxSetBitsDef,
    parameter int MaxWays = MaxWaysDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [3:0]            i_ways_in_use,
    input  logic                  i_req_valid,
    input  logic [MaxSetBits-1:0] i_req_set,
    input  logic [AddrW-2:0]      i_req_tag,
    input  logic                  i_req_last,
    output logic                  o_req_pop,
    output logic                  o_ready,
    output logic                  o_done,
    output logic [1:0]            o_outcome,
    output logic                  o_last_of_access,
    output logic [TotalW-1:0]     o_hit_total,
    output logic [TotalW-1:0]     o_miss_total,
    output logic [TotalW-1:0]     o_eviction_total
);
    localparam int Sets = 1 << MaxSetBits;
    localparam int AgeW = (MaxWays > 1) ? $clog2(MaxWays) : 1;
    localparam int WayW = (MaxWays > 1) ? $clog2(MaxWays) : 1;
    localparam int TagW = AddrW - 1;
    localparam int LineW = 1 + TagW + AgeW;
    localparam int RowW = LineW * MaxWays;
    localparam int CntW = $clog2(Sets + 1);
    localparam logic [1:0] StClear = 2'd0;
    localparam logic [1:0] StIdle = 2'd1;
    localparam logic [1:0] StLook = 2'd2;

    logic [1:0] r_state;
    logic [CntW-1:0] r_clr;
    logic [MaxSetBits-1:0] r_set;
    logic [TagW-1:0] r_tag;
    logic r_last;
    logic [TotalW-1:0] r_hits, r_misses, r_evictions;
    logic [RowW-1:0] rdata, wdata;
    logic we;
    logic [MaxSetBits-1:0] waddr;
    logic [4:0] ways;
    logic [MaxWays-1:0] v, m, inuse;
    logic [TagW-1:0] t [MaxWays];
    logic [AgeW-1:0] a [MaxWays];
    logic found, have_inv;
    logic [WayW-1:0] hit_w, inv_w, old_w, pick;
    logic [AgeW-1:0] best;
    logic [AgeW:0] thr;
    logic [1:0] outcome;
    logic [RowW-1:0] new_row;

    salc_ram #(.Width(RowW), .Depth(Sets)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(i_req_set), .o_rdata(rdata)
    );

    always_comb begin
        ways = (i_ways_in_use == 4'd0) ? 5'd1 : {1'b0, i_ways_in_use};
        if (ways > 5'(MaxWays)) ways = 5'(MaxWays);
        found = 1'b0; have_inv = 1'b0;
        hit_w = '0; inv_w = '0; old_w = '0; best = '0;
        for (int w = 0; w < MaxWays; w++) begin
            inuse[w] = (5'(w) < ways);
            v[w] = rdata[w*LineW + TagW + AgeW];
            t[w] = rdata[w*LineW + AgeW +: TagW];
            a[w] = rdata[w*LineW +: AgeW];
            m[w] = inuse[w] && v[w] && (t[w] == r_tag);
        end
        for (int w = MaxWays - 1; w >= 0; w--) begin
            if (m[w]) begin found = 1'b1; hit_w = WayW'(w); end
            if (inuse[w] && !v[w]) begin have_inv = 1'b1; inv_w = WayW'(w); end
        end
        for (int w = 0; w < MaxWays; w++) begin
            if (inuse[w] && (w == 0 || a[w] > best)) begin
                best = a[w]; old_w = WayW'(w);
            end
        end
        if (found) begin pick = hit_w; outcome = OutHit; end
        else if (have_inv) begin pick = inv_w; outcome = OutFill; end
        else begin pick = old_w; outcome = OutEvict; end
        thr = v[pick] ? {1'b0, a[pick]} : (AgeW+1)'(MaxWays);
        new_row = rdata;
        for (int w = 0; w < MaxWays; w++) begin
            if (WayW'(w) == pick) begin
                new_row[w*LineW +: LineW] = {1'b1, r_tag, AgeW'(0)};
            end else if (inuse[w] && v[w] && ({1'b0, a[w]} < thr)
                         && (a[w] != AgeW'(MaxWays - 1))) begin
                new_row[w*LineW +: AgeW] = a[w] + AgeW'(1);
            end
        end
    end

    assign o_ready = (r_state == StIdle);
    assign o_req_pop = (r_state == StIdle) && i_req_valid;
    assign we = (r_state == StClear) || (r_state == StLook);
    assign waddr = (r_state == StClear) ? r_clr[MaxSetBits-1:0] : r_set;
    assign wdata = (r_state == StClear) ? '0 : new_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StClear;
            r_clr <= '0;
            r_hits <= '0;
            r_misses <= '0;
            r_evictions <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                StClear: begin
                    r_clr <= r_clr + CntW'(1);
                    if (r_clr == CntW'(Sets - 1)) r_state <= StIdle;
                end
                StIdle: begin
                    if (i_req_valid) r_state <= StLook;
                end
                StLook: begin
                    r_state <= StIdle;
                    o_done <= 1'b1;
                    if (found) r_hits <= sat_inc(r_hits);
                    else r_misses <= sat_inc(r_misses);
                    if (!found && !have_inv) r_evictions <= sat_inc(r_evictions);
                end
                default: r_state <= StIdle;
            endcase
        end
        if (o_req_pop) begin
            r_set <= i_req_set;
            r_tag <= i_req_tag;
            r_last <= i_req_last;
        end
        if (r_state == StLook) begin
            o_outcome <= outcome;
            o_last_of_access <= r_last;
        end
    end

    assign o_hit_total = r_hits;
    assign o_miss_total = r_misses;
    assign o_eviction_total = r_evictions;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StLook) |=> o_done)
        else $error("lookup without result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_outcome != 2'd3))
        else $error("bad outcome");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StLook) |-> $countones({found, have_inv && !found}) <= 1)
        else $error("outcome classes overlap");
endmodule

@@ tb/tb_set_assoc_lru_cache_model_top.sv @@
// Self-checking testbench for set_assoc_lru_cache_model_top: a scoreboard class predicts
// every lookup outcome and running total while plain tasks drive accesses and register writes.
// Depends on salc_pkg and the RTL under rtl.
`timescale 1ns / 1ps
module tb_set_assoc_lru_cache_model_top;
    import salc_pkg::*;

    localparam int NumSets = 64;
    localparam int NumWays = 8;
    localparam int CycleLimit = 400000;

    typedef struct {
        logic [1:0]        outcome;
        logic              last;
        logic [TotalW-1:0] hits;
        logic [TotalW-1:0] misses;
        logic [TotalW-1:0] evictions;
    } lookup_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_command = CmdFetch;
    logic [AddrW-1:0]  i_address = '0;
    logic              o_valid;
    logic [1:0]        o_outcome;
    logic              o_last_of_access;
    logic [TotalW-1:0] o_hit_total;
    logic [TotalW-1:0] o_miss_total;
    logic [TotalW-1:0] o_eviction_total;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index = CfgSetBits;
    logic [4:0]        i_cfg_data = '0;

    int errors = 0;
    int cycles = 0;
    int accesses = 0;
    int lookups_seen = 0;
    int outcome_seen[3] = '{0, 0, 0};

    set_assoc_lru_cache_model_top dut (.*);

    always #10 i_clk = ~i_clk;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    class cache_scoreboard;
        bit                line_valid[NumSets*NumWays];
        logic [AddrW-1:0]  line_tag[NumSets*NumWays];
        bit [2:0]          line_age[NumSets*NumWays];
        logic [TotalW-1:0] hits, misses, evictions;
        bit [2:0]          set_bits_r;
        bit [4:0]          block_bits_r;
        bit [3:0]          ways_r;
        lookup_t           pending[$];

        function new();
            foreach (line_valid[i]) begin
                line_valid[i] = 0;
                line_tag[i] = '0;
                line_age[i] = 0;
            end
            hits = '0;
            misses = '0;
            evictions = '0;
            set_bits_r = 1;
            block_bits_r = 1;
            ways_r = 1;
        endfunction

        function int eff_set_bits();
            return set_bits_r < 1 ? 1 : (set_bits_r > 6 ? 6 : set_bits_r);
        endfunction

        function int eff_block_bits();
            return block_bits_r < 1 ? 1 : (block_bits_r > 16 ? 16 : block_bits_r);
        endfunction

        function int eff_ways();
            return ways_r < 1 ? 1 : (ways_r > NumWays ? NumWays : ways_r);
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [4:0] data);
            case (idx)
                CfgSetBits: set_bits_r = data[2:0];
                CfgBlockBits: block_bits_r = data;
                CfgWays: ways_r = data[3:0];
                default: ;
            endcase
        endfunction

        function logic [1:0] lookup(input logic [AddrW-1:0] addr);
            int sb, bb, ways, set_idx, base, pick, threshold;
            logic [AddrW-1:0] tag;
            bit found, have_invalid;
            logic [1:0] res;
            sb = eff_set_bits();
            bb = eff_block_bits();
            ways = eff_ways();
            set_idx = int'((addr >> bb) & ((64'd1 << sb) - 1));
            tag = addr >> (sb + bb);
            base = set_idx * NumWays;
            pick = 0;
            found = 0;
            have_invalid = 0;
            for (int w = 0; w < ways; w++) begin
                if (!found && line_valid[base+w] && line_tag[base+w] == tag) begin
                    pick = w;
                    found = 1;
                end
            end
            if (found) begin
                hits = sat_count(hits);
                res = OutHit;
            end else begin
                misses = sat_count(misses);
                for (int w = 0; w < ways; w++) begin
                    if (!have_invalid && !line_valid[base+w]) begin
                        pick = w;
                        have_invalid = 1;
                    end
                end
                if (have_invalid) begin
                    res = OutFill;
                end else begin
                    pick = 0;
                    for (int w = 1; w < ways; w++) begin
                        if (line_age[base+w] > line_age[base+pick]) pick = w;
                    end
                    evictions = sat_count(evictions);
                    res = OutEvict;
                end
            end
            threshold = line_valid[base+pick] ? line_age[base+pick] : NumWays + 1;
            for (int w = 0; w < ways; w++) begin
                if (w != pick && line_valid[base+w] && line_age[base+w] < threshold
                        && line_age[base+w] < NumWays - 1)
                    line_age[base+w]++;
            end
            line_valid[base+pick] = 1;
            line_tag[base+pick] = tag;
            line_age[base+pick] = 0;
            return res;
        endfunction

        function logic [TotalW-1:0] sat_count(input logic [TotalW-1:0] v);
            return v == TotalMax ? v : v + 1;
        endfunction

        function void push(input logic [1:0] res, input logic last);
            lookup_t r;
            r.outcome = res;
            r.last = last;
            r.hits = hits;
            r.misses = misses;
            r.evictions = evictions;
            pending.push_back(r);
        endfunction

        function void note_access(input logic [1:0] cmd, input logic [AddrW-1:0] addr);
            if (cmd == CmdFetch) return;
            if (cmd == CmdModify) push(lookup(addr), 1'b0);
            push(lookup(addr), 1'b1);
        endfunction

        task check_result(input lookup_t got);
            lookup_t want;
            if (pending.size() == 0) begin
                report("unexpected result", got.outcome, 0);
                return;
            end
            want = pending.pop_front();
            if (got.outcome !== want.outcome) report("outcome", got.outcome, want.outcome);
            if (got.last !== want.last) report("last_of_access", got.last, want.last);
            if (got.hits !== want.hits) report("hit_total", got.hits, want.hits);
            if (got.misses !== want.misses) report("miss_total", got.misses, want.misses);
            if (got.evictions !== want.evictions)
                report("eviction_total", got.evictions, want.evictions);
        endtask
    endclass

    cache_scoreboard board = new();
    logic [AddrW-1:0] addr_pool[32];

    always @(posedge i_clk) begin
        lookup_t got;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            got.outcome = o_outcome;
            got.last = o_last_of_access;
            got.hits = o_hit_total;
            got.misses = o_miss_total;
            got.evictions = o_eviction_total;
            lookups_seen++;
            if (o_outcome <= OutEvict) outcome_seen[o_outcome]++;
            board.check_result(got);
        end
    end

    task automatic send_access(input logic [1:0] cmd, input logic [AddrW-1:0] addr);
        start <= 1'b1;
        i_command <= cmd;
        i_address <= addr;
        do @(posedge i_clk); while (busy);
        board.note_access(cmd, addr);
        accesses++;
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [4:0] sb, input logic [4:0] bb, input logic [4:0] wy);
        drain();
        write_reg(CfgSetBits, sb);
        write_reg(CfgBlockBits, bb);
        write_reg(CfgWays, wy);
        for (int i = 0; i < 32; i++) begin
            logic [AddrW-1:0] tag;
            int s, b;
            s = board.eff_set_bits();
            b = board.eff_block_bits();
            tag = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : $urandom_range(0, 15);
            addr_pool[i] = (tag << (s + b)) | (AddrW'($urandom_range(0, 3)) << b);
        end
    endtask

    function automatic logic [AddrW-1:0] pick_address();
        logic [AddrW-1:0] a;
        if ($urandom_range(0, 9) < 2) return {$urandom, $urandom};
        a = addr_pool[$urandom_range(0, 31)];
        return a ^ (AddrW'($urandom) & ((AddrW'(1) << board.eff_block_bits()) - 1));
    endfunction

    task automatic random_phase(input int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
            end
            burst--;
            if (i == n / 2) drain();
            send_access(2'($urandom_range(0, 3)), pick_address());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_access(CmdLoad, '0);
        send_access(CmdStore, '0);
        send_access(CmdLoad, '1);
        send_access(CmdModify, '1);
        send_access(CmdFetch, 64'h1234);
        send_access(CmdModify, 64'h8000_0000_0000_0000);
        send_access(CmdStore, 64'h0000_0000_0000_0001);
        send_access(CmdLoad, 64'h10);
        send_access(CmdLoad, 64'h14);
        send_access(CmdFetch, '1);
        set_config(5'd6, 5'd16, 5'd8);
        for (int i = 0; i < 10; i++) send_access(CmdLoad, AddrW'(i) << 22);
        send_access(CmdModify, 64'h0);
        send_access(CmdLoad, 64'h7fff_ffff_ffff_ffff);
        random_phase(150);
        set_config(5'd0, 5'd0, 5'd0);
        random_phase(130);
        set_config(5'd7, 5'd31, 5'd15);
        random_phase(130);
        set_config(5'd1, 5'd17, 5'd9);
        random_phase(120);
        set_config(5'd2, 5'd4, 5'd4);
        random_phase(140);
        set_config(5'd3, 5'd5, 5'd2);
        random_phase(130);
        drain();
        repeat (20) @(posedge i_clk);

        $display("covered %0d accesses, %0d lookups over seven register settings",
                 accesses, lookups_seen);
        $display("outcomes: %0d hits, %0d fills, %0d evictions",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2]);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
